[hw/rtl/bilinear_image_scaler_defines.svh]
// assertion macros for the bilinear scaler
// no dependencies
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH
// implication checked every clock outside reset
`define BIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define BIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/bis_pkg.sv]
// shared types and constants for the bilinear scaler
// no dependencies
package bis_pkg;
    localparam int CHAN_W = 8;
    localparam int NCHAN = 3;
    localparam int FRAC_W = 12;
    localparam int WGT_W = 9;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_REQ = 1'b1;
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_RSTEP = 2'd2;
    localparam logic [1:0] REG_CSTEP = 2'd3;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NCHAN*CHAN_W-1:0] pix_t;
    typedef struct packed {
        logic valid;
        logic in_range;
        logic [WGT_W-1:0] wr;
        logic [WGT_W-1:0] wc;
    } ctl_t;
endpackage

[hw/rtl/bis_store.sv]
// four-bank frame store, one bank per neighbour position (row and col parity)
// depends on bis_pkg
module bis_store #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512,
    parameter int RW = 9,
    parameter int CW = 9
) (
    input  logic aclk,
    input  logic en,
    input  logic wr_en,
    input  logic [RW-1:0] wr_row,
    input  logic [CW-1:0] wr_col,
    input  bis_pkg::pix_t wr_data,
    input  logic [RW-1:0] r0,
    input  logic [RW-1:0] r1,
    input  logic [CW-1:0] c0,
    input  logic [CW-1:0] c1,
    output bis_pkg::pix_t q00,
    output bis_pkg::pix_t q01,
    output bis_pkg::pix_t q10,
    output bis_pkg::pix_t q11
);
    localparam int HR = (MAX_ROWS + 1) / 2;
    localparam int HC = (MAX_COLS + 1) / 2;
    localparam int BD = HR * HC;
    localparam int AW = $clog2(BD);
    // each bank holds one row parity by col parity
    bis_pkg::pix_t bank0 [BD];
    bis_pkg::pix_t bank1 [BD];
    bis_pkg::pix_t bank2 [BD];
    bis_pkg::pix_t bank3 [BD];
    bis_pkg::pix_t d0_reg, d1_reg, d2_reg, d3_reg;
    logic sr_reg, sc_reg;
    logic eqr_reg, eqc_reg;
    logic [AW-1:0] wa, ae_e, ae_o, ao_e, ao_o;
    logic [RW-1:0] re, ro;
    logic [CW-1:0] ce, co;
    logic swr, swc;
    logic eqr, eqc;

    function automatic logic [AW-1:0] baddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        baddr = AW'((r >> 1) * HC + (c >> 1));
    endfunction

    // even/odd row and col among the two neighbours
    always_comb begin
        swr = r0[0];
        swc = c0[0];
        eqr = (r0 == r1);
        eqc = (c0 == c1);
        re = swr ? r1 : r0;
        ro = swr ? r0 : r1;
        ce = swc ? c1 : c0;
        co = swc ? c0 : c1;
        wa = baddr(wr_row, wr_col);
        ae_e = baddr(re, ce);
        ae_o = baddr(re, co);
        ao_e = baddr(ro, ce);
        ao_o = baddr(ro, co);
    end

    // write one bank, read all four
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            unique case ({wr_row[0], wr_col[0]})
                2'b00: bank0[wa] <= wr_data;
                2'b01: bank1[wa] <= wr_data;
                2'b10: bank2[wa] <= wr_data;
                2'b11: bank3[wa] <= wr_data;
                default: ;
            endcase
        end
        if (en) begin
            d0_reg <= bank0[ae_e];
            d1_reg <= bank1[ae_o];
            d2_reg <= bank2[ao_e];
            d3_reg <= bank3[ao_o];
            sr_reg <= swr;
            sc_reg <= swc;
            eqr_reg <= eqr;
            eqc_reg <= eqc;
        end
    end

    // route banks back to neighbour order, clamped neighbour reuses the near one
    always_comb begin
        bis_pkg::pix_t e0, e1, o0, o1;
        e0 = sc_reg ? d1_reg : d0_reg;
        e1 = sc_reg ? d0_reg : d1_reg;
        o0 = sc_reg ? d3_reg : d2_reg;
        o1 = sc_reg ? d2_reg : d3_reg;
        q00 = sr_reg ? o0 : e0;
        q01 = eqc_reg ? q00 : (sr_reg ? o1 : e1);
        q10 = eqr_reg ? q00 : (sr_reg ? e0 : o0);
        q11 = eqr_reg ? q01 : (eqc_reg ? q10 : (sr_reg ? e1 : o1));
    end
endmodule

[hw/rtl/bis_lane.sv]
// one channel lane: two-stage bilinear blend
// depends on bis_pkg
module bis_lane (
    input  logic aclk,
    input  logic en,
    input  bis_pkg::chan_t a,
    input  bis_pkg::chan_t b,
    input  bis_pkg::chan_t c,
    input  bis_pkg::chan_t d,
    input  logic [bis_pkg::WGT_W-1:0] wc,
    input  logic [bis_pkg::WGT_W-1:0] wr_in,
    output bis_pkg::chan_t v
);
    logic [15:0] top_reg, bot_reg;
    logic [24:0] sum;
    logic [bis_pkg::WGT_W-1:0] nwc;
    logic [bis_pkg::WGT_W-1:0] nwr;

    // column blend, registered; row blend after
    always_comb begin
        nwc = 9'd256 - wc;
        nwr = 9'd256 - wr_in;
        sum = 25'(top_reg * nwr) + 25'(bot_reg * wr_in);
        v = sum[23:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg <= 16'(a * nwc + b * wc);
            bot_reg <= 16'(c * nwc + d * wc);
        end
    end
endmodule

[hw/rtl/bilinear_image_scaler.sv]
// request words pass stages s1 to s4 to the result word, one word accepted per cycle unless the output stalls
// throughput set by the four-bank frame store reading all neighbours at once
// loads pass through the lw1 and lw2 registers to the store and produce no result
// synchronous active-low reset clears the pipeline valids and sets the config registers to defaults
// frame store content is undefined after reset until loaded
module bilinear_image_scaler #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_action,
    input  logic [11:0] s_pixel_row,
    input  logic [11:0] s_pixel_col,
    input  logic [7:0] s_load_chan0,
    input  logic [7:0] s_load_chan1,
    input  logic [7:0] s_load_chan2,
    output logic m_valid,
    input  logic m_ready,
    output logic m_in_range,
    output logic [7:0] m_out_chan0,
    output logic [7:0] m_out_chan1,
    output logic [7:0] m_out_chan2
);
`include "bilinear_image_scaler_defines.svh"
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int SW = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1;

    logic [9:0] rows_reg, cols_reg;
    logic [15:0] rstep_reg, cstep_reg;
    logic [SW-1:0] erows, ecols;
    logic adv;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 10'd512;
            cols_reg <= 10'd512;
            rstep_reg <= 16'd6827;
            cstep_reg <= 16'd6827;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bis_pkg::REG_ROWS: rows_reg <= cfg_data[9:0];
                bis_pkg::REG_COLS: cols_reg <= cfg_data[9:0];
                bis_pkg::REG_RSTEP: rstep_reg <= cfg_data;
                bis_pkg::REG_CSTEP: cstep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        erows = (32'(rows_reg) < 32'(MAX_ROWS)) ? SW'(rows_reg) : SW'(MAX_ROWS);
        ecols = (32'(cols_reg) < 32'(MAX_COLS)) ? SW'(cols_reg) : SW'(MAX_COLS);
    end

    // pipeline: s1 multiply, s2 address/range, s3 read, s4 blend
    logic c1v_reg;
    bis_pkg::ctl_t c2_reg, c3_reg;
    logic [27:0] rpos_reg, cpos_reg;
    logic [RW-1:0] r0_reg, r1_reg;
    logic [CW-1:0] c0_reg, c1c_reg;
    logic out_v_reg, out_ir_reg;
    bis_pkg::chan_t o0_reg, o1_reg, o2_reg;
    // load words follow the request timing so the store sees words in order
    logic lw1_v_reg, lw2_v_reg;
    logic [RW-1:0] lw1_row_reg, lw2_row_reg;
    logic [CW-1:0] lw1_col_reg, lw2_col_reg;
    bis_pkg::pix_t lw1_data_reg, lw2_data_reg;

    assign adv = !out_v_reg || m_ready;
    assign s_ready = adv;

    logic acc, ld;
    assign acc = s_valid && s_ready;
    assign ld = acc && (s_action == bis_pkg::ACT_LOAD) &&
                (32'(s_pixel_row) < 32'(MAX_ROWS)) && (32'(s_pixel_col) < 32'(MAX_COLS));

    // coordinate mapping and neighbour selection
    logic [15:0] rnear, cnear, rfl, cfl;
    logic rin, cin;
    logic [RW-1:0] r0n, r1n;
    logic [CW-1:0] c0n, c1n;
    always_comb begin
        rnear = 16'((rpos_reg + 28'd2048) >> 12);
        cnear = 16'((cpos_reg + 28'd2048) >> 12);
        rfl = 16'(rpos_reg >> 12);
        cfl = 16'(cpos_reg >> 12);
        rin = rnear < 16'(erows);
        cin = cnear < 16'(ecols);
        r0n = RW'(rfl);
        c0n = CW'(cfl);
        r1n = (rfl + 16'd1 < 16'(erows)) ? RW'(rfl + 16'd1) : RW'(erows - SW'(1));
        c1n = (cfl + 16'd1 < 16'(ecols)) ? CW'(cfl + 16'd1) : CW'(ecols - SW'(1));
    end

    // pipeline registers, valids cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1v_reg <= 1'b0;
            c2_reg.valid <= 1'b0;
            c3_reg.valid <= 1'b0;
            out_v_reg <= 1'b0;
            lw1_v_reg <= 1'b0;
            lw2_v_reg <= 1'b0;
        end else if (adv) begin
            c1v_reg <= acc && (s_action == bis_pkg::ACT_REQ);
            c2_reg.valid <= c1v_reg;
            c3_reg.valid <= c2_reg.valid;
            out_v_reg <= c3_reg.valid;
            lw1_v_reg <= ld;
            lw2_v_reg <= lw1_v_reg;
            lw1_row_reg <= RW'(s_pixel_row);
            lw1_col_reg <= CW'(s_pixel_col);
            lw1_data_reg <= {s_load_chan2, s_load_chan1, s_load_chan0};
            lw2_row_reg <= lw1_row_reg;
            lw2_col_reg <= lw1_col_reg;
            lw2_data_reg <= lw1_data_reg;
            rpos_reg <= 28'(s_pixel_row * rstep_reg);
            cpos_reg <= 28'(s_pixel_col * cstep_reg);
            c2_reg.in_range <= rin && cin;
            c2_reg.wr <= {1'b0, rpos_reg[11:4]};
            c2_reg.wc <= {1'b0, cpos_reg[11:4]};
            r0_reg <= r0n;
            r1_reg <= r1n;
            c0_reg <= c0n;
            c1c_reg <= c1n;
            c3_reg.in_range <= c2_reg.in_range;
            c3_reg.wr <= c2_reg.wr;
            c3_reg.wc <= c2_reg.wc;
            out_ir_reg <= c3_reg.in_range;
        end
    end

    // frame store
    bis_pkg::pix_t q00, q01, q10, q11;
    bis_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RW(RW), .CW(CW)) u_store (
        .aclk(aclk), .en(adv), .wr_en(lw2_v_reg && adv),
        .wr_row(lw2_row_reg), .wr_col(lw2_col_reg),
        .wr_data(lw2_data_reg),
        .r0(r0_reg), .r1(r1_reg), .c0(c0_reg), .c1(c1c_reg),
        .q00(q00), .q01(q01), .q10(q10), .q11(q11)
    );

    // three channel lanes
    bis_pkg::chan_t lv [bis_pkg::NCHAN];
    logic [bis_pkg::WGT_W-1:0] wr4_reg;
    always_ff @(posedge aclk) if (adv) wr4_reg <= c3_reg.wr;
    for (genvar g = 0; g < bis_pkg::NCHAN; g++) begin : g_lane
        bis_lane u_lane (
            .aclk(aclk), .en(adv),
            .a(q00[g*8 +: 8]), .b(q01[g*8 +: 8]), .c(q10[g*8 +: 8]), .d(q11[g*8 +: 8]),
            .wc(c3_reg.wc), .wr_in(wr4_reg), .v(lv[g])
        );
    end

    // merge lanes into the result word
    always_comb begin
        o0_reg = out_ir_reg ? lv[0] : '0;
        o1_reg = out_ir_reg ? lv[1] : '0;
        o2_reg = out_ir_reg ? lv[2] : '0;
    end
    assign m_valid = out_v_reg;
    assign m_in_range = out_ir_reg;
    assign m_out_chan0 = o0_reg;
    assign m_out_chan1 = o1_reg;
    assign m_out_chan2 = o2_reg;

    `BIS_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_out_chan0))
    `BIS_ASSERT_IMP(a_zero_out, m_valid && !m_in_range,
        m_out_chan0 == 8'd0 && m_out_chan1 == 8'd0 && m_out_chan2 == 8'd0)
    `BIS_ASSERT_IMP(a_ready, !m_valid, s_ready)
endmodule
